@@ design/mac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_pkg
// Types and constants shared by the memory admission controller.
// ----------------------------------------------------------------------------
package mac_pkg;

   localparam int MAX_RUNNING   = 16;
   localparam int PENDING_DEPTH = 16;
   localparam int MEM_BITS      = 24;

   localparam int RUN_IDX_BITS    = $clog2(MAX_RUNNING);
   localparam int RUN_COUNT_BITS  = $clog2(MAX_RUNNING + 1);
   localparam int PEND_IDX_BITS   = $clog2(PENDING_DEPTH);
   localparam int PEND_COUNT_BITS = $clog2(PENDING_DEPTH + 1);

   localparam int ID_BITS    = 5;
   localparam int SLOTS_BITS = 5;
   localparam int CSR_BITS   = 24;

   localparam logic [SLOTS_BITS-1:0] RESET_SLOTS = SLOTS_BITS'(4);
   localparam logic [MEM_BITS-1:0]   RESET_TOTAL = MEM_BITS'(65536);

   typedef enum logic {
      CSR_PROCESS_SLOTS = 1'b0,
      CSR_MEMORY_TOTAL  = 1'b1
   } csr_index_type;

   typedef enum logic {
      ACT_CREATE = 1'b0,
      ACT_KILL   = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      EV_ADMITTED = 3'd0,
      EV_PENDED   = 3'd1,
      EV_REJECTED = 3'd2,
      EV_KILLED   = 3'd3,
      EV_PROMOTED = 3'd4,
      EV_BAD_ID   = 3'd5
   } event_type;

   typedef struct packed {
      action_type          action;
      logic [MEM_BITS-1:0] request_memory;
      logic [ID_BITS-1:0]  kill_id;
   } req_type;

   typedef struct packed {
      event_type           event_res;
      logic [ID_BITS-1:0]  job_id;
      logic [MEM_BITS-1:0] job_memory;
      logic [MEM_BITS-1:0] free_memory;
      logic                last;
   } rsp_type;

endpackage

@@ design/memory_admission_controller_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// memory_admission_controller_unit
// Admits, queues and kills memory jobs; a kill compacts the running table and
// promotes queued jobs in order while the queue head fits.
// ----------------------------------------------------------------------------
//  channel   ports                              handshake
//  request   start, busy, req_data              start && !busy
//  result    rsp_valid, rsp_data                rsp_valid, one cycle each
//  csr       csr_we, csr_index, csr_data        csr_we, no wait, idle only
//
//  a create goes from ST_DECIDE straight to its single result
//  a kill passes ST_KREAD, then ST_CMP_RD and ST_CMP_WR per entry moved by
//  compaction, then ST_HEAD_RD and ST_CHECK per job promoted and once more;
//  the registered read of the running table sets the two states per moved entry
//  busy drops in the cycle the last result of a request is shown
//  reset (synchronous) empties both tables and loads the pool with 65536
//  results cannot be stalled; each is valid for exactly one cycle
// ----------------------------------------------------------------------------
module memory_admission_controller_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  mac_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   output mac_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  mac_pkg::csr_index_type              csr_index,
   input  logic [mac_pkg::CSR_BITS-1:0]        csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_KREAD,
      ST_CMP_RD,
      ST_CMP_WR,
      ST_HEAD_RD,
      ST_CHECK
   } state_type;

   state_type                                   state_ff, state_in;
   logic                                        busy_ff, busy_in;
   logic                                        rsp_valid_ff, rsp_valid_in;
   mac_pkg::rsp_type                            rsp_data_ff, rsp_data_in;
   mac_pkg::rsp_type                            held_ff, held_in;
   mac_pkg::req_type                            req_ff, req_in;
   logic [mac_pkg::RUN_IDX_BITS-1:0]            pos_ff, pos_in;
   logic [mac_pkg::RUN_COUNT_BITS-1:0]          run_count_ff, run_count_in;
   logic [mac_pkg::PEND_IDX_BITS-1:0]           pend_head_ff, pend_head_in;
   logic [mac_pkg::PEND_COUNT_BITS-1:0]         pend_count_ff, pend_count_in;
   logic [mac_pkg::MEM_BITS-1:0]                pool_ff, pool_in;
   logic [mac_pkg::SLOTS_BITS-1:0]              slots_ff, slots_in;

   logic [mac_pkg::MEM_BITS-1:0]                run_mem [mac_pkg::MAX_RUNNING];
   logic [mac_pkg::MEM_BITS-1:0]                pend_mem [mac_pkg::PENDING_DEPTH];
   logic [mac_pkg::MEM_BITS-1:0]                run_rdata_ff;
   logic [mac_pkg::MEM_BITS-1:0]                pend_rdata_ff;

   logic                                        run_we;
   logic [mac_pkg::RUN_IDX_BITS-1:0]            run_waddr, run_raddr;
   logic [mac_pkg::MEM_BITS-1:0]                run_wdata;
   logic                                        pend_we;
   logic [mac_pkg::PEND_IDX_BITS-1:0]           pend_waddr;
   logic [mac_pkg::MEM_BITS-1:0]                pend_wdata;

   logic [mac_pkg::SLOTS_BITS-1:0]              slot_limit;
   logic                                        slot_free;
   logic [mac_pkg::ID_BITS-1:0]                 kill_pos;
   logic [mac_pkg::RUN_IDX_BITS:0]              next_pos;
   logic [mac_pkg::MEM_BITS:0]                  pool_sum;
   logic                                        promote_ok;

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign slot_limit = (slots_ff < mac_pkg::SLOTS_BITS'(mac_pkg::MAX_RUNNING)) ?
                       slots_ff : mac_pkg::SLOTS_BITS'(mac_pkg::MAX_RUNNING);
   assign slot_free  = mac_pkg::SLOTS_BITS'(run_count_ff) < slot_limit;
   assign kill_pos   = req_ff.kill_id - mac_pkg::ID_BITS'(1);
   assign next_pos   = {1'b0, pos_ff} + (mac_pkg::RUN_IDX_BITS + 1)'(1);
   assign pool_sum   = {1'b0, pool_ff} + {1'b0, run_rdata_ff};
   assign promote_ok = (pend_count_ff != '0) && slot_free && (pend_rdata_ff <= pool_ff);

   // running table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (run_we) begin
         run_mem[run_waddr] <= run_wdata;
      end
      run_rdata_ff <= run_mem[run_raddr];
   end

   // pending queue, circular
   always_ff @(posedge clock) begin
      if (pend_we) begin
         pend_mem[pend_waddr] <= pend_wdata;
      end
      pend_rdata_ff <= pend_mem[pend_head_ff];
   end

   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      held_in       = held_ff;
      req_in        = req_ff;
      pos_in        = pos_ff;
      run_count_in  = run_count_ff;
      pend_head_in  = pend_head_ff;
      pend_count_in = pend_count_ff;
      pool_in       = pool_ff;
      slots_in      = slots_ff;
      run_we        = 1'b0;
      run_waddr     = run_count_ff[mac_pkg::RUN_IDX_BITS-1:0];
      run_wdata     = req_ff.request_memory;
      run_raddr     = kill_pos[mac_pkg::RUN_IDX_BITS-1:0];
      pend_we       = 1'b0;
      pend_waddr    = pend_head_ff + pend_count_ff[mac_pkg::PEND_IDX_BITS-1:0];
      pend_wdata    = req_ff.request_memory;

      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               case (csr_index)
                  mac_pkg::CSR_PROCESS_SLOTS: begin
                     slots_in = csr_data[mac_pkg::SLOTS_BITS-1:0];
                  end
                  mac_pkg::CSR_MEMORY_TOTAL: begin
                     pool_in  = csr_data[mac_pkg::MEM_BITS-1:0];
                  end
                  default: begin
                     slots_in = slots_ff;
                  end
               endcase
            end
            if (start) begin
               req_in   = req_data;
               busy_in  = 1'b1;
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            rsp_data_in.job_id     = '0;
            rsp_data_in.job_memory = req_ff.request_memory;
            rsp_data_in.last       = 1'b1;
            if (req_ff.action == mac_pkg::ACT_CREATE) begin
               rsp_valid_in = 1'b1;
               busy_in      = 1'b0;
               state_in     = ST_IDLE;
               if ((req_ff.request_memory <= pool_ff) && slot_free) begin
                  run_we                  = 1'b1;
                  pool_in                 = pool_ff - req_ff.request_memory;
                  run_count_in            = run_count_ff + mac_pkg::RUN_COUNT_BITS'(1);
                  rsp_data_in.event_res   = mac_pkg::EV_ADMITTED;
                  rsp_data_in.job_id      = mac_pkg::ID_BITS'(run_count_in);
                  rsp_data_in.free_memory = pool_in;
               end else if (pend_count_ff <
                            mac_pkg::PEND_COUNT_BITS'(mac_pkg::PENDING_DEPTH)) begin
                  pend_we                 = 1'b1;
                  pend_count_in           = pend_count_ff + mac_pkg::PEND_COUNT_BITS'(1);
                  rsp_data_in.event_res   = mac_pkg::EV_PENDED;
                  rsp_data_in.free_memory = pool_ff;
               end else begin
                  rsp_data_in.event_res   = mac_pkg::EV_REJECTED;
                  rsp_data_in.free_memory = pool_ff;
               end
            end else if ((req_ff.kill_id == '0) ||
                         (req_ff.kill_id > mac_pkg::ID_BITS'(run_count_ff))) begin
               rsp_valid_in            = 1'b1;
               busy_in                 = 1'b0;
               state_in                = ST_IDLE;
               rsp_data_in.event_res   = mac_pkg::EV_BAD_ID;
               rsp_data_in.job_memory  = '0;
               rsp_data_in.free_memory = pool_ff;
            end else begin
               pos_in   = kill_pos[mac_pkg::RUN_IDX_BITS-1:0];
               state_in = ST_KREAD;
            end
         end

         ST_KREAD: begin
            held_in.event_res  = mac_pkg::EV_KILLED;
            held_in.job_id     = '0;
            held_in.job_memory = run_rdata_ff;
            held_in.last       = 1'b0;
            pool_in            = pool_sum[mac_pkg::MEM_BITS] ? '1 :
                                 pool_sum[mac_pkg::MEM_BITS-1:0];
            state_in           = ST_CMP_RD;
         end

         ST_CMP_RD: begin
            run_raddr = next_pos[mac_pkg::RUN_IDX_BITS-1:0];
            if (mac_pkg::RUN_COUNT_BITS'(next_pos) < run_count_ff) begin
               state_in = ST_CMP_WR;
            end else begin
               run_count_in        = run_count_ff - mac_pkg::RUN_COUNT_BITS'(1);
               held_in.free_memory = pool_ff;
               state_in            = ST_HEAD_RD;
            end
         end

         ST_CMP_WR: begin
            run_we    = 1'b1;
            run_waddr = pos_ff;
            run_wdata = run_rdata_ff;
            pos_in    = next_pos[mac_pkg::RUN_IDX_BITS-1:0];
            state_in  = ST_CMP_RD;
         end

         ST_HEAD_RD: begin
            state_in = ST_CHECK;
         end

         ST_CHECK: begin
            rsp_valid_in     = 1'b1;
            rsp_data_in      = held_ff;
            rsp_data_in.last = !promote_ok;
            if (promote_ok) begin
               run_we              = 1'b1;
               run_wdata           = pend_rdata_ff;
               pool_in             = pool_ff - pend_rdata_ff;
               run_count_in        = run_count_ff + mac_pkg::RUN_COUNT_BITS'(1);
               pend_head_in        = pend_head_ff + mac_pkg::PEND_IDX_BITS'(1);
               pend_count_in       = pend_count_ff - mac_pkg::PEND_COUNT_BITS'(1);
               held_in.event_res   = mac_pkg::EV_PROMOTED;
               held_in.job_id      = mac_pkg::ID_BITS'(run_count_in);
               held_in.job_memory  = pend_rdata_ff;
               held_in.free_memory = pool_in;
               held_in.last        = 1'b0;
               state_in            = ST_HEAD_RD;
            end else begin
               busy_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end

         default: begin
            busy_in  = 1'b0;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         run_count_ff  <= '0;
         pend_head_ff  <= '0;
         pend_count_ff <= '0;
         slots_ff      <= mac_pkg::RESET_SLOTS;
         pool_ff       <= mac_pkg::RESET_TOTAL;
      end else begin
         state_ff      <= state_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         run_count_ff  <= run_count_in;
         pend_head_ff  <= pend_head_in;
         pend_count_ff <= pend_count_in;
         slots_ff      <= slots_in;
         pool_ff       <= pool_in;
      end
      rsp_data_ff <= rsp_data_in;
      held_ff     <= held_in;
      req_ff      <= req_in;
      pos_ff      <= pos_in;
   end

endmodule
